[sv/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HTW_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("huffman decoder check failed");

// Next-cycle implication.
`define HTW_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("huffman decoder check failed");

`endif

[sv/htw_pkg.sv]
// Shared types and constants of the Huffman tree-walk decoder.
package htw_pkg;

   localparam int NODE_COUNT = 256;
   localparam int NODE_AW    = $clog2(NODE_COUNT);
   localparam int SYM_W      = 7;
   localparam int BYTE_BITS  = 8;
   localparam int CNT_W      = $clog2(BYTE_BITS + 1);
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   // Register index decoded from the word address
   localparam logic REG_ROOT_INDEX = 1'b0;

   // Request kinds
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // One code tree node as stored in the node memory
   typedef struct packed {
      logic [NODE_AW-1:0] left;
      logic [NODE_AW-1:0] right;
      logic               leaf;
      logic [SYM_W-1:0]   sym;
   } node_type;

   // Bit shifter control and status
   typedef struct packed {
      logic load;
      logic shift;
   } shift_ctl_type;

   typedef struct packed {
      logic cur_bit;
      logic next_bit;
      logic one_left;
   } shift_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_CHILD,
      ST_DONE
   } state_type;

endpackage

[sv/htw_node_ram.sv]
// Node table memory: one write port, one registered read port.
module htw_node_ram import htw_pkg::*; (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [NODE_AW-1:0] wr_addr,
   input  node_type           wr_data,
   input  logic               rd_en,
   input  logic [NODE_AW-1:0] rd_addr,
   output node_type           rd_data
);

   node_type mem [NODE_COUNT];
   node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds when no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/htw_bit_shift.sv]
// Compressed byte shift register: hands out one bit per step, MSB first.
module htw_bit_shift import htw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  shift_ctl_type        ctl,
   input  logic [BYTE_BITS-1:0] data_byte,
   input  logic [CNT_W-1:0]     bit_count,
   output shift_sts_type        sts
);

   logic [BYTE_BITS-1:0] data_ff, data_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   always_comb begin
      data_in = data_ff;
      cnt_in  = cnt_ff;
      if (ctl.load) begin
         data_in = data_byte;
         cnt_in  = bit_count;
      end else if (ctl.shift) begin
         data_in = {data_ff[BYTE_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign sts.cur_bit  = data_ff[BYTE_BITS-1];
   assign sts.next_bit = data_ff[BYTE_BITS-2];
   assign sts.one_left = (cnt_ff == CNT_W'(1));

endmodule

[sv/huffman_tree_walk_decoder.sv]
// Huffman tree-walk decoder. A load request (mode 0) writes one node of the
// 256-entry code tree. A decode request (mode 1) walks the tree one
// compressed bit at a time, MSB first, emitting a symbol at each leaf that a
// bit leads to; the walk position carries over between bytes and returns to
// root_index after a byte flagged last_byte, whose trailing pad_bits are
// skipped. No new request is taken until the byte is done. The walk is paced
// by the single read port of the node memory: every bit's child read depends
// on the previous read, and restarting at the root after a leaf costs one
// more read. Results pass through a holding register and an output register,
// so a held result stalls the walk only when the walk finds another symbol,
// or ends the byte, while both are full. Node entries are undefined until
// loaded.
`include "assert_macros.svh"

module huffman_tree_walk_decoder import htw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [NODE_AW-1:0]   req_node_index,
   input  logic [NODE_AW-1:0]   req_left_child,
   input  logic [NODE_AW-1:0]   req_right_child,
   input  logic                 req_is_leaf,
   input  logic [SYM_W-1:0]     req_leaf_symbol,
   input  logic [BYTE_BITS-1:0] req_data_byte,
   input  logic                 req_last_byte,
   input  logic [2:0]           req_pad_bits,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SYM_W-1:0]     rsp_symbol,
   output logic                 rsp_last_of_byte,
   // register port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_AW-1:0]    paddr,
   input  logic [CSR_DW-1:0]    pwdata,
   output logic [CSR_DW-1:0]    prdata,
   output logic                 pready
);

   state_type state_ff, state_in;

   logic [NODE_AW-1:0] root_ff, root_in;
   logic [NODE_AW-1:0] cur_ff, cur_in;
   logic [NODE_AW-1:0] next_ff, next_in;
   logic               last_ff, last_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]   pend_sym_ff, pend_sym_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]   rsp_symbol_ff, rsp_symbol_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               out_free;
   logic               stall;
   logic               push;
   logic               push_last;
   logic [CNT_W-1:0]   nbits;

   logic               wr_en;
   node_type           wr_data;
   logic               rd_en;
   logic [NODE_AW-1:0] rd_addr;
   node_type           ent;

   shift_ctl_type      shift_ctl;
   shift_sts_type      shift_sts;

   // Register port: single root index register
   assign pready = 1'b1;
   assign prdata = CSR_DW'(root_ff);

   always_comb begin
      root_in = root_ff;
      if (psel && penable && pwrite && pready && paddr[2] == REG_ROOT_INDEX) begin
         root_in = pwdata[NODE_AW-1:0];
      end
   end

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign stall    = pend_valid_ff && !out_free;
   assign nbits    = req_last_byte ? (CNT_W'(BYTE_BITS) - CNT_W'(req_pad_bits))
                                   : CNT_W'(BYTE_BITS);

   assign wr_data = '{left: req_left_child, right: req_right_child,
                      leaf: req_is_leaf, sym: req_leaf_symbol};

   htw_node_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_node_index),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ent)
   );

   htw_bit_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .ctl       (shift_ctl),
      .data_byte (req_data_byte),
      .bit_count (nbits),
      .sts       (shift_sts)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_DECODE) begin
               state_in = (nbits == '0) ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (ent.leaf) begin
               state_in = shift_sts.one_left ? ST_DONE : ST_WALK;
            end else begin
               state_in = ST_CHILD;
            end
         end
         ST_CHILD: begin
            if (ent.leaf) begin
               if (!stall) begin
                  state_in = shift_sts.one_left ? ST_DONE : ST_WALK;
               end
            end else begin
               state_in = shift_sts.one_left ? ST_DONE : ST_CHILD;
            end
         end
         ST_DONE: begin
            if (!stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control per state
   always_comb begin
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;
      shift_ctl     = '0;
      cur_in        = cur_ff;
      next_in       = next_ff;
      last_in       = last_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      push          = 1'b0;
      push_last     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_LOAD) begin
                  wr_en = 1'b1;
               end else begin
                  shift_ctl.load = 1'b1;
                  last_in        = req_last_byte;
                  rd_en          = 1'b1;
                  rd_addr        = cur_ff;
               end
            end
         end
         ST_WALK: begin
            // ent holds the node the walk stands on
            if (ent.leaf) begin
               shift_ctl.shift = 1'b1;
               cur_in          = root_ff;
               rd_en           = 1'b1;
               rd_addr         = root_ff;
            end else begin
               next_in = shift_sts.cur_bit ? ent.right : ent.left;
               rd_en   = 1'b1;
               rd_addr = next_in;
            end
         end
         ST_CHILD: begin
            // ent holds the child reached by the current bit
            if (ent.leaf) begin
               if (!stall) begin
                  shift_ctl.shift = 1'b1;
                  cur_in          = root_ff;
                  rd_en           = 1'b1;
                  rd_addr         = root_ff;
                  push            = pend_valid_ff;
                  pend_valid_in   = 1'b1;
                  pend_sym_in     = ent.sym;
               end
            end else begin
               shift_ctl.shift = 1'b1;
               cur_in          = next_ff;
               next_in         = shift_sts.next_bit ? ent.right : ent.left;
               rd_en           = 1'b1;
               rd_addr         = next_in;
            end
         end
         ST_DONE: begin
            // flush the held symbol as the last of this byte
            if (!stall) begin
               push          = pend_valid_ff;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               if (last_ff) begin
                  cur_in = root_ff;
               end
            end
         end
         default: ;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = pend_sym_ff;
         rsp_last_in   = push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      next_ff       <= next_in;
      pend_sym_ff   <= pend_sym_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         root_ff       <= '0;
         cur_ff        <= '0;
         last_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root_ff       <= root_in;
         cur_ff        <= cur_in;
         last_ff       <= last_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol       = rsp_symbol_ff;
   assign rsp_last_of_byte = rsp_last_ff;

   // Checks
   `HTW_ASSERT_IMP(a_idle_no_pend, state_ff == ST_IDLE, !pend_valid_ff)
   `HTW_ASSERT_NXT(a_done_flush, state_ff == ST_DONE && !stall, !pend_valid_ff && state_ff == ST_IDLE)
   `HTW_ASSERT_NXT(a_last_to_root, state_ff == ST_DONE && !stall && last_ff, cur_ff == $past(root_ff))
   `HTW_ASSERT_IMP(a_push_free, push, out_free)

endmodule

[tb/huffman_tree_walk_decoder_tb.sv]
// Self-checking testbench for the Huffman tree-walk decoder: node loads, byte decodes, root register.
module huffman_tree_walk_decoder_tb import htw_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_AW-1:0] ROOT_ADDR = {REG_ROOT_INDEX, 2'b00};
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 20;

   // one request as offered on the input channel
   typedef struct {
      logic                 mode;
      logic [NODE_AW-1:0]   node_index;
      logic [NODE_AW-1:0]   left_child;
      logic [NODE_AW-1:0]   right_child;
      logic                 is_leaf;
      logic [SYM_W-1:0]     leaf_symbol;
      logic [BYTE_BITS-1:0] data_byte;
      logic                 last_byte;
      logic [2:0]           pad_bits;
   } request_type;

   // one decoded symbol as it should leave the block
   typedef struct {
      logic [SYM_W-1:0] sym;
      logic             last;
   } decoded_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_mode = 1'b0;
   logic [NODE_AW-1:0]   req_node_index = '0;
   logic [NODE_AW-1:0]   req_left_child = '0;
   logic [NODE_AW-1:0]   req_right_child = '0;
   logic                 req_is_leaf = 1'b0;
   logic [SYM_W-1:0]     req_leaf_symbol = '0;
   logic [BYTE_BITS-1:0] req_data_byte = '0;
   logic                 req_last_byte = 1'b0;
   logic [2:0]           req_pad_bits = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [SYM_W-1:0]     rsp_symbol;
   logic                 rsp_last_of_byte;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [CSR_AW-1:0]    paddr = '0;
   logic [CSR_DW-1:0]    pwdata = '0;
   logic [CSR_DW-1:0]    prdata;
   logic                 pready;

   // stimulus side
   request_type request_q[$];
   request_type offered;
   int          queued_count = 0;
   int          accepted_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          gen_loaded[NODE_COUNT] = '{default: 1'b0};
   bit          gen_tree[NODE_COUNT] = '{default: 1'b0};

   // decoder shadow state
   node_type           tree_mem[NODE_COUNT] = '{default: '0};
   logic [NODE_AW-1:0] walk_at = '0;
   logic [NODE_AW-1:0] root_reg = '0;
   decoded_type        decoded_q[$];

   int   errors = 0;
   logic hold_go = 1'b0;
   bit   hold_used = 1'b0;
   int   hold_left = 0;

   huffman_tree_walk_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_node_index   (req_node_index),
      .req_left_child   (req_left_child),
      .req_right_child  (req_right_child),
      .req_is_leaf      (req_is_leaf),
      .req_leaf_symbol  (req_leaf_symbol),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_pad_bits     (req_pad_bits),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_last_of_byte (rsp_last_of_byte),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one accepted request to the shadow tree and queue the symbols it yields
   task automatic walk_code_tree(input request_type r);
      node_type           here;
      node_type           child;
      logic [NODE_AW-1:0] nxt;
      decoded_type        found[$];
      decoded_type        d;
      int                 nbits;
      int                 i;
      if (r.mode == MODE_LOAD) begin
         tree_mem[r.node_index] = '{left: r.left_child, right: r.right_child,
                                    leaf: r.is_leaf, sym: r.leaf_symbol};
         return;
      end
      nbits = r.last_byte ? BYTE_BITS - int'(r.pad_bits) : BYTE_BITS;
      for (i = 0; i < nbits; i++) begin
         here = tree_mem[walk_at];
         if (here.leaf) begin
            // standing on a leaf: bit is swallowed, restart at root
            walk_at = root_reg;
         end else begin
            nxt = r.data_byte[BYTE_BITS-1-i] ? here.right : here.left;
            child = tree_mem[nxt];
            if (child.leaf) begin
               d.sym = child.sym;
               d.last = 1'b0;
               found.push_back(d);
               walk_at = root_reg;
            end else begin
               walk_at = nxt;
            end
         end
      end
      if (found.size() != 0) found[found.size()-1].last = 1'b1;
      foreach (found[k]) decoded_q.push_back(found[k]);
      if (r.last_byte) walk_at = root_reg;
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            walk_code_tree(offered);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = request_q.pop_front();
               req_valid       <= 1'b1;
               req_mode        <= offered.mode;
               req_node_index  <= offered.node_index;
               req_left_child  <= offered.left_child;
               req_right_child <= offered.right_child;
               req_is_leaf     <= offered.is_leaf;
               req_leaf_symbol <= offered.leaf_symbol;
               req_data_byte   <= offered.data_byte;
               req_last_byte   <= offered.last_byte;
               req_pad_bits    <= offered.pad_bits;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, armed once
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end
   end

   // Result monitor
   always @(posedge clock) begin
      decoded_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual symbol %0h last %0b",
                        $time, rsp_symbol, rsp_last_of_byte);
               errors++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_symbol !== want.sym) begin
                  $display("%0t: symbol mismatch: expected %0h, actual %0h",
                           $time, want.sym, rsp_symbol);
                  errors++;
               end
               if (rsp_last_of_byte !== want.last) begin
                  $display("%0t: last_of_byte mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_last_of_byte);
                  errors++;
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_load(input int idx, input int lft, input int rgt,
                             input bit leaf, input int sym);
      request_type r;
      r.mode        = MODE_LOAD;
      r.node_index  = NODE_AW'(idx);
      r.left_child  = NODE_AW'(lft);
      r.right_child = NODE_AW'(rgt);
      r.is_leaf     = leaf;
      r.leaf_symbol = SYM_W'(sym);
      // decode fields are don't-care on a load
      r.data_byte   = BYTE_BITS'($urandom);
      r.last_byte   = 1'($urandom);
      r.pad_bits    = 3'($urandom);
      request_q.push_back(r);
      queued_count++;
      gen_loaded[idx] = 1'b1;
   endtask

   task automatic queue_decode(input int data, input bit last, input int pad);
      request_type r;
      r.mode        = MODE_DECODE;
      r.data_byte   = BYTE_BITS'(data);
      r.last_byte   = last;
      r.pad_bits    = 3'(pad);
      // load fields are don't-care on a decode
      r.node_index  = NODE_AW'($urandom);
      r.left_child  = NODE_AW'($urandom);
      r.right_child = NODE_AW'($urandom);
      r.is_leaf     = 1'($urandom);
      r.leaf_symbol = SYM_W'($urandom);
      request_q.push_back(r);
      queued_count++;
   endtask

   function automatic int unused_index(input bit taken[NODE_COUNT]);
      int idx;
      do idx = $urandom_range(NODE_COUNT - 1); while (taken[idx]);
      return idx;
   endfunction

   // Grow a random full binary tree from the root and queue a load per node
   task automatic queue_tree(input int root, input int leaves);
      bit taken[NODE_COUNT];
      int tips[$];
      int inner[$];
      int inner_l[$];
      int inner_r[$];
      int pick;
      int lft;
      int rgt;
      taken = '{default: 1'b0};
      taken[root] = 1'b1;
      tips.push_back(root);
      while (tips.size() < leaves) begin
         pick = $urandom_range(tips.size() - 1);
         inner.push_back(tips[pick]);
         tips.delete(pick);
         lft = unused_index(taken);
         taken[lft] = 1'b1;
         rgt = unused_index(taken);
         taken[rgt] = 1'b1;
         inner_l.push_back(lft);
         inner_r.push_back(rgt);
         tips.push_back(lft);
         tips.push_back(rgt);
      end
      foreach (inner[k]) queue_load(inner[k], inner_l[k], inner_r[k], 1'b0, $urandom_range(127));
      foreach (tips[k])
         queue_load(tips[k], $urandom_range(255), $urandom_range(255), 1'b1, $urandom_range(127));
      gen_tree = taken;
   endtask

   // New tree, then a stream of bytes with some node rewrites mixed in.
   // Internal nodes only ever point at loaded entries, so no walk reads an unwritten node.
   task automatic queue_random_phase(input int root, input int count);
      int n;
      int idx;
      int kid_l;
      int kid_r;
      queue_tree(root, $urandom_range(2, 8));
      for (n = 0; n < count; n++) begin
         idx = $urandom_range(NODE_COUNT - 1);
         if ($urandom_range(99) < 12 && idx != root) begin
            if (gen_tree[idx] || $urandom_range(1)) begin
               queue_load(idx, $urandom_range(255), $urandom_range(255), 1'b1,
                          $urandom_range(127));
            end else begin
               do kid_l = $urandom_range(NODE_COUNT - 1); while (!gen_loaded[kid_l]);
               do kid_r = $urandom_range(NODE_COUNT - 1); while (!gen_loaded[kid_r]);
               queue_load(idx, kid_l, kid_r, 1'b0, $urandom_range(127));
            end
         end else begin
            queue_decode($urandom_range(255), $urandom_range(99) < 15, $urandom_range(7));
         end
      end
   endtask

   // Wait until every request is taken and every symbol is back, then let the walk settle
   task automatic drain_block();
      while (accepted_count != queued_count || decoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write root_index, then read it back
   task automatic write_root(input int value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ROOT_ADDR;
      pwdata  <= CSR_DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      root_reg = NODE_AW'(value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DW'(value)) begin
         $display("%0t: root_index readback mismatch: expected %0h, actual %0h",
                  $time, value, prdata);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Main sequence
   initial begin
      int r;
      send_idle_pct = 20;
      recv_idle_pct = 62;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_root(0);

      // Directed tree at root 0: code 0 -> 127, 10 -> 0, 11 -> 55h
      queue_load(0, 255, 2, 1'b0, 0);
      queue_load(255, 255, 0, 1'b1, 127);
      queue_load(2, 3, 4, 1'b0, 127);
      queue_load(3, 0, 255, 1'b1, 0);
      queue_load(4, 170, 85, 1'b1, 'h55);
      queue_decode('h00, 1'b0, 0);      // eight symbols from one byte
      queue_decode('hFF, 1'b0, 0);
      queue_decode('hAA, 1'b0, 7);      // pad ignored when not last
      queue_decode('hB7, 1'b0, 0);      // code left open across the byte boundary
      queue_decode('h7F, 1'b1, 7);      // last byte, single bit used
      queue_decode('h80, 1'b1, 7);      // last byte ending mid-code: no symbol
      queue_decode('hC0, 1'b1, 0);
      queue_decode('h01, 1'b0, 0);      // leaves the walk on node 2
      queue_load(2, 85, 170, 1'b1, 'h2A);  // node under the walk becomes a leaf
      queue_decode('h00, 1'b0, 0);
      queue_load(2, 3, 4, 1'b0, 0);
      queue_load(0, 0, 0, 1'b1, 'h11);  // root itself is a leaf
      queue_decode('h5A, 1'b1, 3);
      queue_load(0, 255, 2, 1'b0, 0);
      queue_decode('hFF, 1'b1, 0);
      drain_block();

      // Random phases over several roots and idle mixes
      write_root(255);
      queue_random_phase(255, PHASE_ITEMS);
      drain_block();

      send_idle_pct = 62;
      recv_idle_pct = 20;
      r = $urandom_range(1, 254);
      write_root(r);
      queue_random_phase(r, PHASE_ITEMS);
      drain_block();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_root(0);
      @(posedge clock);
      hold_go <= 1'b1;
      queue_random_phase(0, PHASE_ITEMS);
      drain_block();

      if (errors == 0 && decoded_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #200000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/htw_pkg.sv
sv/htw_node_ram.sv
sv/htw_bit_shift.sv
sv/huffman_tree_walk_decoder.sv
tb/huffman_tree_walk_decoder_tb.sv
